FILE: sv/first_fit_region_block_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit region block allocator
// Each macro expects clk and rst in scope; checks are off while rst is high.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_REGION_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_REGION_BLOCK_ALLOCATOR_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define FFA_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define FFA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Sizes, request codes and controller/datapath interface types of the
// first-fit region block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

  // Memory geometry
  localparam int NUM_BLOCKS      = 1024;
  localparam int REALTIME_BLOCKS = 64;
  localparam int RT_LIMIT        = (REALTIME_BLOCKS > NUM_BLOCKS) ?
                                   NUM_BLOCKS : REALTIME_BLOCKS;

  // Field widths
  localparam int KIND_W  = 2;
  localparam int CNT_W   = 11;
  localparam int START_W = 10;

  // Internal widths
  localparam int ADDR_W = $clog2(NUM_BLOCKS);
  localparam int PTR_W  = $clog2(NUM_BLOCKS + 1);
  localparam int SUM_W  = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_FREE  = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_CHECK = KIND_W'(2);

  typedef logic [PTR_W-1:0] ptr_t;

  // Result selection
  typedef enum logic [1:0] {
    RES_FAIL     = 2'd0,  // success 0, start 0
    RES_OK_NOPOS = 2'd1,  // success 1, start 0
    RES_OK_LO    = 2'd2,  // success 1, start at region base
    RES_OK_RUN   = 2'd3   // success 1, start of found run
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic mark_start;
    logic free_start;
    logic wr_step;
    logic wr_bit;
    logic res_set;
    res_t res;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              cnt_zero;
    logic              cnt_big;
    logic              free_empty;
    logic              scan_hit;
    logic              scan_miss;
    logic              wr_last;
    logic              out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: sv/ffa_dpath.sv
// ----------------------------------------------------------------------------
// ffa_dpath
// Used-block bitmap memory, request registers, scan/write pointer, run
// counter and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_dpath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire ffa_pkg::cmd_t                cmd,
  output ffa_pkg::sts_t                     sts,
  input  wire logic [ffa_pkg::KIND_W-1:0]   kind,
  input  wire logic [ffa_pkg::CNT_W-1:0]    block_count,
  input  wire logic                         realtime_region,
  input  wire logic [ffa_pkg::START_W-1:0]  release_start,
  input  wire logic                         out_stall,
  output logic                              out_valid,
  output logic                              success,
  output logic [ffa_pkg::START_W-1:0]       start_block
);

  // Bitmap, one bit per block
  logic mem [ffa_pkg::NUM_BLOCKS];
  logic rd_data;

  // Latched request
  logic [ffa_pkg::KIND_W-1:0]  kind_q;
  logic [ffa_pkg::CNT_W-1:0]   cnt_q;
  logic                        rt_q;
  logic [ffa_pkg::START_W-1:0] first_q;

  // Pointers and scan state
  ffa_pkg::ptr_t             ptr;
  ffa_pkg::ptr_t             wr_end;
  ffa_pkg::ptr_t             ev_ptr;
  logic                      ev_vld;
  logic [ffa_pkg::CNT_W-1:0] run;

  // Pending result
  logic                        res_success;
  logic [ffa_pkg::START_W-1:0] res_start;

  // Derived values
  ffa_pkg::ptr_t             lo;
  ffa_pkg::ptr_t             hi;
  ffa_pkg::ptr_t             span;
  ffa_pkg::ptr_t             ptr_inc;
  logic [ffa_pkg::SUM_W-1:0] cnt_ext;
  logic [ffa_pkg::SUM_W-1:0] free_sum;
  logic [ffa_pkg::SUM_W-1:0] free_end;
  logic [ffa_pkg::SUM_W-1:0] where_sum;
  logic [ffa_pkg::CNT_W-1:0] run_inc;
  logic                      rd_issue;

  function automatic ffa_pkg::ptr_t realtime_sel_lo(input logic rt);
    realtime_sel_lo = rt ? '0 : ffa_pkg::PTR_W'(ffa_pkg::RT_LIMIT);
  endfunction

  // Region bounds, free range and run arithmetic
  always_comb begin
    lo        = realtime_sel_lo(rt_q);
    hi        = rt_q ? ffa_pkg::PTR_W'(ffa_pkg::RT_LIMIT)
                     : ffa_pkg::PTR_W'(ffa_pkg::NUM_BLOCKS);
    span      = hi - lo;
    ptr_inc   = ptr + ffa_pkg::PTR_W'(1);
    cnt_ext   = ffa_pkg::SUM_W'(cnt_q);
    free_sum  = ffa_pkg::SUM_W'(first_q) + cnt_ext;
    free_end  = (free_sum > ffa_pkg::SUM_W'(ffa_pkg::NUM_BLOCKS)) ?
                ffa_pkg::SUM_W'(ffa_pkg::NUM_BLOCKS) : free_sum;
    where_sum = ffa_pkg::SUM_W'(ev_ptr) + ffa_pkg::SUM_W'(1) - cnt_ext;
    run_inc   = run + ffa_pkg::CNT_W'(1);
    rd_issue  = ptr < hi;
  end

  // Status
  always_comb begin
    sts.kind       = kind_q;
    sts.cnt_zero   = (cnt_q == '0);
    sts.cnt_big    = (cnt_ext > ffa_pkg::SUM_W'(span));
    sts.free_empty = (ffa_pkg::SUM_W'(first_q) >= free_end);
    sts.scan_hit   = ev_vld && !rd_data && (run_inc == cnt_q);
    sts.scan_miss  = !ev_vld && !rd_issue;
    sts.wr_last    = (ptr_inc == wr_end);
    sts.out_free   = !out_valid || !out_stall;
  end

  // Bitmap write and registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_step) begin
      mem[ptr[ffa_pkg::ADDR_W-1:0]] <= cmd.wr_bit;
    end
    if (cmd.scan_step) begin
      rd_data <= mem[ptr[ffa_pkg::ADDR_W-1:0]];
    end
  end

  // Request word capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q  <= kind;
      cnt_q   <= block_count;
      rt_q    <= realtime_region;
      first_q <= release_start;
    end
  end

  // Pointer, scan and write range control; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr    <= '0;
      wr_end <= ffa_pkg::PTR_W'(ffa_pkg::NUM_BLOCKS);
      ev_vld <= 1'b0;
      run    <= '0;
    end else begin
      if (cmd.scan_start) begin
        ptr    <= lo;
        run    <= '0;
        ev_vld <= 1'b0;
      end
      if (cmd.scan_step) begin
        ev_vld <= rd_issue;
        ev_ptr <= ptr;
        if (rd_issue) begin
          ptr <= ptr_inc;
        end
        if (ev_vld) begin
          run <= rd_data ? '0 : run_inc;
        end
      end
      if (cmd.mark_start) begin
        ptr    <= ffa_pkg::PTR_W'(where_sum);
        wr_end <= ev_ptr + ffa_pkg::PTR_W'(1);
      end
      if (cmd.free_start) begin
        ptr    <= ffa_pkg::PTR_W'(first_q);
        wr_end <= ffa_pkg::PTR_W'(free_end);
      end
      if (cmd.wr_step) begin
        ptr <= ptr_inc;
      end
    end
  end

  // Pending result
  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      case (cmd.res)
        ffa_pkg::RES_FAIL: begin
          res_success <= 1'b0;
          res_start   <= '0;
        end
        ffa_pkg::RES_OK_NOPOS: begin
          res_success <= 1'b1;
          res_start   <= '0;
        end
        ffa_pkg::RES_OK_LO: begin
          res_success <= 1'b1;
          res_start   <= ffa_pkg::START_W'(lo);
        end
        ffa_pkg::RES_OK_RUN: begin
          res_success <= 1'b1;
          res_start   <= ffa_pkg::START_W'(where_sum);
        end
        default: begin
          res_success <= 1'b0;
          res_start   <= '0;
        end
      endcase
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      success     <= res_success;
      start_block <= res_start;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ffa_ctrl.sv
// ----------------------------------------------------------------------------
// ffa_ctrl
// Request sequencer: clearing pass, decode, first-fit scan, run marking,
// release and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire ffa_pkg::sts_t sts,
  output ffa_pkg::cmd_t      cmd
);

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_DECODE = 7'b0000100,
    ST_SCAN   = 7'b0001000,
    ST_MARK   = 7'b0010000,
    ST_FREE   = 7'b0100000,
    ST_RESP   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  // Only the idle state takes a request word
  assign in_stall = (state != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res    = ffa_pkg::RES_FAIL;
    case (state)
      ST_CLEAR: begin
        cmd.wr_step = 1'b1;
        cmd.wr_bit  = 1'b0;
        if (sts.wr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.res_set = 1'b1;
        case (sts.kind)
          ffa_pkg::KIND_FREE: begin
            cmd.res = ffa_pkg::RES_OK_NOPOS;
            if (sts.free_empty) begin
              state_next = ST_RESP;
            end else begin
              cmd.free_start = 1'b1;
              state_next     = ST_FREE;
            end
          end
          ffa_pkg::KIND_ALLOC, ffa_pkg::KIND_CHECK: begin
            if (sts.cnt_big) begin
              cmd.res    = ffa_pkg::RES_FAIL;
              state_next = ST_RESP;
            end else if (sts.cnt_zero) begin
              // zero-block request: succeeds and marks nothing; an allocate reports the region base
              cmd.res    = (sts.kind == ffa_pkg::KIND_ALLOC) ?
                           ffa_pkg::RES_OK_LO : ffa_pkg::RES_OK_NOPOS;
              state_next = ST_RESP;
            end else begin
              cmd.res_set    = 1'b0;
              cmd.scan_start = 1'b1;
              state_next     = ST_SCAN;
            end
          end
          default: begin
            cmd.res    = ffa_pkg::RES_FAIL;
            state_next = ST_RESP;
          end
        endcase
      end
      ST_SCAN: begin
        if (sts.scan_hit) begin
          cmd.res_set = 1'b1;
          if (sts.kind == ffa_pkg::KIND_ALLOC) begin
            cmd.res        = ffa_pkg::RES_OK_RUN;
            cmd.mark_start = 1'b1;
            state_next     = ST_MARK;
          end else begin
            cmd.res    = ffa_pkg::RES_OK_NOPOS;
            state_next = ST_RESP;
          end
        end else if (sts.scan_miss) begin
          cmd.res_set = 1'b1;
          cmd.res     = ffa_pkg::RES_FAIL;
          state_next  = ST_RESP;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_MARK: begin
        cmd.wr_step = 1'b1;
        cmd.wr_bit  = 1'b1;
        if (sts.wr_last) begin
          state_next = ST_RESP;
        end
      end
      ST_FREE: begin
        cmd.wr_step = 1'b1;
        cmd.wr_bit  = 1'b0;
        if (sts.wr_last) begin
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/first_fit_region_block_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_region_block_allocator
// First-fit contiguous block allocator over a used/free bitmap with a
// real-time region and a user region.
// ----------------------------------------------------------------------------
// One request word is taken at a time. After reset the bitmap is cleared one
// block per cycle, so the input stalls until all NUM_BLOCKS (1024) blocks are
// clear. An allocate or check is taken in the idle state and decoded in the
// decode state, then the scan reads one bitmap bit per cycle through a single
// memory port, stopping at the first fitting run. An allocate then marks the
// run at one block per cycle. A free writes one block per cycle over the
// released range. The response state hands the result to the output register
// once that register is free; it holds the result while the next request word
// is taken. Worst case is an allocate of the whole user region: a full scan
// plus a full mark.
`default_nettype none

module first_fit_region_block_allocator (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [ffa_pkg::KIND_W-1:0]   kind,
  input  wire logic [ffa_pkg::CNT_W-1:0]    block_count,
  input  wire logic                         realtime_region,
  input  wire logic [ffa_pkg::START_W-1:0]  release_start,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              success,
  output logic [ffa_pkg::START_W-1:0]       start_block
);

  ffa_pkg::cmd_t cmd;
  ffa_pkg::sts_t sts;

  // Sequencer
  ffa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Bitmap and datapath
  ffa_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .kind            (kind),
    .block_count     (block_count),
    .realtime_region (realtime_region),
    .release_start   (release_start),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .success         (success),
    .start_block     (start_block)
  );

endmodule

`default_nettype wire

FILE: sv/ffa_checker.sv
// ----------------------------------------------------------------------------
// ffa_checker
// Port-level checks of the first-fit region block allocator, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "first_fit_region_block_allocator_assert.svh"

module ffa_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic                        success,
  input wire logic [ffa_pkg::START_W-1:0] start_block
);

  // A stalled result word holds
  `FFA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(success) && $stable(start_block), "result word changed while stalled")

  // A failed request reports no start block
  `FFA_ASSERT_SAME(a_fail_no_start, out_valid && !success, start_block == '0, "failure with nonzero start block")

  // One request word at a time: taking a word closes the input
  `FFA_ASSERT_NEXT(a_one_word, in_valid && !in_stall, in_stall, "input open right after a word was taken")

  // The clearing pass keeps the input closed after reset
  `FFA_ASSERT_SAME(a_clear_after_reset, $fell(rst), in_stall, "input open during clearing pass")

endmodule

bind first_fit_region_block_allocator ffa_checker u_ffa_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .success     (success),
  .start_block (start_block)
);

`default_nettype wire
